### src/matrix3x3_inverse_defines.svh
// Assertion macros used by the matrix inverse checker.
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define M3I_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define M3I_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/m3i_pkg.sv
// Types, widths and helpers for the 3x3 matrix inverse.
`default_nettype none
package m3i_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW     = 32;               // entry width
  localparam int PW     = 2 * DW;           // product width
  localparam int CW     = PW + 1;           // signed cofactor
  localparam int MW     = PW;               // cofactor magnitude
  localparam int LO_W   = DW;               // low split of a cofactor for det terms
  localparam int DETW   = 99;               // signed determinant
  localparam int DMW    = DETW - 1;         // determinant magnitude
  localparam int TOL_W  = 31;
  localparam int NW     = MW + 2 * FRAC_BITS; // dividend width
  localparam int QB     = DW;               // quotient bits before rounding
  localparam int CMPW   = DMW + QB + 1;     // compare width in the divider
  localparam int NCOF   = 9;
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic signed [DW-1:0] a_00;
    logic signed [DW-1:0] a_01;
    logic signed [DW-1:0] a_02;
    logic signed [DW-1:0] a_10;
    logic signed [DW-1:0] a_11;
    logic signed [DW-1:0] a_12;
    logic signed [DW-1:0] a_20;
    logic signed [DW-1:0] a_21;
    logic signed [DW-1:0] a_22;
  } in_word_t;

  typedef struct packed {
    logic signed [DW-1:0] inv_00;
    logic signed [DW-1:0] inv_01;
    logic signed [DW-1:0] inv_02;
    logic signed [DW-1:0] inv_10;
    logic signed [DW-1:0] inv_11;
    logic signed [DW-1:0] inv_12;
    logic signed [DW-1:0] inv_20;
    logic signed [DW-1:0] inv_21;
    logic signed [DW-1:0] inv_22;
    logic                 invertible;
  } out_word_t;

  // Classified matrix handed from front to back.
  typedef struct packed {
    logic [NCOF-1:0][MW-1:0] mag;
    logic [NCOF-1:0]         neg;
    logic [DMW-1:0]          dmag;
    logic                    dneg;
    logic                    inv;
  } item_t;

  // Clamp a magnitude to the output range and apply the sign.
  function automatic logic signed [DW-1:0] sat_round(input logic neg,
                                                     input logic [MW:0] m);
    logic [MW:0]   lim;
    logic [DW-1:0] mm;
    lim = neg ? ((MW+1)'(1) << (DW - 1)) : (((MW+1)'(1) << (DW - 1)) - 1'b1);
    mm  = (m > lim) ? lim[DW-1:0] : m[DW-1:0];
    return neg ? -mm : mm;
  endfunction

endpackage
`default_nettype wire

### src/m3i_front.sv
// Front: products, cofactors, determinant and singular classification.
`default_nettype none
module m3i_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire m3i_pkg::in_word_t           in_word,
  input  wire logic [m3i_pkg::TOL_W-1:0]   tol,
  input  wire logic                        q_full,
  output logic                             push,
  output m3i_pkg::item_t                   push_item
);

  localparam int ST = 5;
  localparam int NP = 2 * m3i_pkg::NCOF;
  // factor indexes of the two products of each cofactor
  localparam int FA [NP] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int FB [NP] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};
  // cofactors paired with row 0 in the determinant
  localparam int DI [3]  = '{0, 3, 6};

  logic [ST-1:0] v_r;
  logic          en;

  logic signed [m3i_pkg::DW-1:0]   a [m3i_pkg::NCOF];
  logic signed [m3i_pkg::PW-1:0]   p_r [NP];
  logic signed [m3i_pkg::DW-1:0]   ar1_r [3];
  logic signed [m3i_pkg::CW-1:0]   cof_r [m3i_pkg::NCOF];
  logic signed [m3i_pkg::DW-1:0]   ar2_r [3];
  logic signed [m3i_pkg::CW-1:0]   pl_r [3];
  logic signed [m3i_pkg::CW-1:0]   ph_r [3];
  logic signed [m3i_pkg::CW-1:0]   cof3_r [m3i_pkg::NCOF];
  logic signed [m3i_pkg::DETW-1:0] det_r;
  logic signed [m3i_pkg::DETW-1:0] det_nxt;
  logic [m3i_pkg::MW-1:0]          mag4_r [m3i_pkg::NCOF];
  logic [m3i_pkg::NCOF-1:0]        neg4_r;
  logic signed [m3i_pkg::CW-1:0]   cabs [m3i_pkg::NCOF];
  logic signed [m3i_pkg::DETW-1:0] dabs;
  logic [m3i_pkg::DMW-1:0]         tol_ext;
  m3i_pkg::item_t                  item_r;
  m3i_pkg::item_t                  item_nxt;

  // front moves as one while the queue has room
  assign en        = !q_full;
  assign in_stall  = q_full;
  assign push      = en && v_r[ST-1];
  assign push_item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ST-2:0], in_valid};
    end
  end

  always_comb begin
    a[0] = in_word.a_00; a[1] = in_word.a_01; a[2] = in_word.a_02;
    a[3] = in_word.a_10; a[4] = in_word.a_11; a[5] = in_word.a_12;
    a[6] = in_word.a_20; a[7] = in_word.a_21; a[8] = in_word.a_22;
  end

  // stage 1: eighteen 32x32 products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NP; i++) p_r[i] <= a[FA[i]] * a[FB[i]];
      ar1_r[0] <= a[0];
      ar1_r[1] <= a[1];
      ar1_r[2] <= a[2];
    end
  end

  // stage 2: cofactors, exact
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < m3i_pkg::NCOF; k++)
        cof_r[k] <= m3i_pkg::CW'(p_r[2*k]) - m3i_pkg::CW'(p_r[2*k+1]);
      ar2_r <= ar1_r;
    end
  end

  // stage 3: determinant terms split in low and high partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pl_r[k] <= ar2_r[k] * signed'({1'b0, cof_r[DI[k]][m3i_pkg::LO_W-1:0]});
        ph_r[k] <= ar2_r[k] * signed'(cof_r[DI[k]][m3i_pkg::CW-1:m3i_pkg::LO_W]);
      end
      cof3_r <= cof_r;
    end
  end

  // stage 4: determinant sum and cofactor magnitudes
  always_comb begin
    det_nxt = '0;
    for (int k = 0; k < 3; k++)
      det_nxt = det_nxt + (m3i_pkg::DETW'(ph_r[k]) <<< m3i_pkg::LO_W)
                + m3i_pkg::DETW'(pl_r[k]);
    for (int k = 0; k < m3i_pkg::NCOF; k++)
      cabs[k] = cof3_r[k][m3i_pkg::CW-1] ? -cof3_r[k] : cof3_r[k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= det_nxt;
      for (int k = 0; k < m3i_pkg::NCOF; k++) begin
        mag4_r[k] <= cabs[k][m3i_pkg::MW-1:0];
        neg4_r[k] <= cof3_r[k][m3i_pkg::CW-1];
      end
    end
  end

  // stage 5: |det| against the tolerance at the determinant's scale
  always_comb begin
    dabs    = det_r[m3i_pkg::DETW-1] ? -det_r : det_r;
    tol_ext = m3i_pkg::DMW'({tol, {(2 * m3i_pkg::FRAC_BITS){1'b0}}});
    for (int k = 0; k < m3i_pkg::NCOF; k++) item_nxt.mag[k] = mag4_r[k];
    item_nxt.neg  = neg4_r;
    item_nxt.dmag = dabs[m3i_pkg::DMW-1:0];
    item_nxt.dneg = det_r[m3i_pkg::DETW-1];
    item_nxt.inv  = dabs[m3i_pkg::DMW-1:0] > tol_ext;
  end

  always_ff @(posedge clk) begin
    if (en) item_r <= item_nxt;
  end

endmodule
`default_nettype wire

### src/m3i_queue.sv
// Short queue between front and back.
`default_nettype none
module m3i_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire m3i_pkg::item_t  push_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output m3i_pkg::item_t       pop_item
);

  localparam int AW   = (m3i_pkg::QDEPTH > 1) ? $clog2(m3i_pkg::QDEPTH) : 1;
  localparam int CNTW = $clog2(m3i_pkg::QDEPTH + 1);

  m3i_pkg::item_t  mem [m3i_pkg::QDEPTH];
  logic [AW-1:0]   wr_r, rd_r;
  logic [CNTW-1:0] cnt_r;

  assign full     = cnt_r == CNTW'(m3i_pkg::QDEPTH);
  assign empty    = cnt_r == '0;
  assign pop_item = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(m3i_pkg::QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == AW'(m3i_pkg::QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + CNTW'(push) - CNTW'(pop);
    end
  end

endmodule
`default_nettype wire

### src/m3i_lane.sv
// One result entry: restoring divide pipeline, rounding and saturation.
`default_nettype none
module m3i_lane (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic [m3i_pkg::MW-1:0]                 mag,
  input  wire logic                                   neg,
  input  wire logic                                   dneg,
  input  wire logic [m3i_pkg::DMW-1:0]                dmag,
  input  wire logic [m3i_pkg::QB:0][m3i_pkg::DMW-1:0] dm,
  input  wire logic                                   inv_last,
  output logic signed [m3i_pkg::DW-1:0]               res
);

  localparam int QB  = m3i_pkg::QB;
  localparam int NW  = m3i_pkg::NW;
  localparam int CMPW = m3i_pkg::CMPW;

  logic [NW-1:0]                 r_r    [QB+1];
  logic [QB-1:0]                 q_r    [QB+1];
  logic                          ovf_r  [QB+2];
  logic                          sneg_r [QB+2];
  logic signed [m3i_pkg::DW-1:0] sing_r [QB+2];
  logic [QB:0]                   qf_r;
  logic signed [m3i_pkg::DW-1:0] res_r;
  logic [NW-1:0]                 n0;
  logic                          up;
  logic signed [m3i_pkg::DW-1:0] div_val;

  assign n0  = {mag, {(2 * m3i_pkg::FRAC_BITS){1'b0}}};
  assign res = res_r;

  // entry stage: dividend, overflow check, singular value
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= n0;
      q_r[0]    <= '0;
      ovf_r[0]  <= CMPW'(n0) >= (CMPW'(dmag) << QB);
      sneg_r[0] <= neg ^ dneg;
      sing_r[0] <= m3i_pkg::sat_round(neg,
                     (m3i_pkg::MW+1)'(mag >> m3i_pkg::FRAC_BITS)
                     + (m3i_pkg::MW+1)'(mag[m3i_pkg::FRAC_BITS-1]));
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int SH = QB - 1 - j;
    logic [CMPW-1:0] dsh;
    logic            ge;
    assign dsh = CMPW'(dm[j]) << SH;
    assign ge  = CMPW'(r_r[j]) >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j+1]    <= ge ? r_r[j] - dsh[NW-1:0] : r_r[j];
        q_r[j+1]    <= {q_r[j][QB-2:0], ge};
        ovf_r[j+1]  <= ovf_r[j];
        sneg_r[j+1] <= sneg_r[j];
        sing_r[j+1] <= sing_r[j];
      end
    end
  end

  // round half away from zero: remainder at least half the divisor
  assign up = CMPW'({r_r[QB], 1'b0}) >= CMPW'(dm[QB]);

  always_ff @(posedge clk) begin
    if (en) begin
      qf_r         <= (QB+1)'(q_r[QB]) + (QB+1)'(up);
      ovf_r[QB+1]  <= ovf_r[QB];
      sneg_r[QB+1] <= sneg_r[QB];
      sing_r[QB+1] <= sing_r[QB];
    end
  end

  // saturate and pick quotient or unscaled adjugate
  assign div_val = m3i_pkg::sat_round(sneg_r[QB+1],
                     ovf_r[QB+1] ? '1 : (m3i_pkg::MW+1)'(qf_r));

  always_ff @(posedge clk) begin
    if (en) res_r <= inv_last ? div_val : sing_r[QB+1];
  end

endmodule
`default_nettype wire

### src/m3i_back.sv
// Back: nine divide lanes fed from the queue, with the output register.
`default_nettype none
module m3i_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire m3i_pkg::item_t     q_item,
  output logic                    pop,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output m3i_pkg::out_word_t      out_word
);

  localparam int QB = m3i_pkg::QB;

  logic                                   en;
  logic [QB+1:0]                          bv_r;
  logic [QB+1:0]                          iv_r;
  logic [QB:0][m3i_pkg::DMW-1:0]          dm_r;
  logic                                   out_valid_r;
  logic                                   flag_r;
  logic signed [m3i_pkg::DW-1:0]          res [m3i_pkg::NCOF];

  // whole back pipe advances unless a result waits on a stalled receiver
  assign en        = !out_valid_r || !out_stall;
  assign pop       = en && !q_empty;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      bv_r        <= {bv_r[QB:0], pop};
      out_valid_r <= bv_r[QB+1];
    end
  end

  // divisor and flag travel alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      dm_r   <= {dm_r[QB-1:0], q_item.dmag};
      iv_r   <= {iv_r[QB:0], q_item.inv};
      flag_r <= iv_r[QB+1];
    end
  end

  for (genvar k = 0; k < m3i_pkg::NCOF; k++) begin : g_lane
    m3i_lane u_lane (
      .clk      (clk),
      .en       (en),
      .mag      (q_item.mag[k]),
      .neg      (q_item.neg[k]),
      .dneg     (q_item.dneg),
      .dmag     (q_item.dmag),
      .dm       (dm_r),
      .inv_last (iv_r[QB+1]),
      .res      (res[k])
    );
  end

  always_comb begin
    out_word.inv_00     = res[0];
    out_word.inv_01     = res[1];
    out_word.inv_02     = res[2];
    out_word.inv_10     = res[3];
    out_word.inv_11     = res[4];
    out_word.inv_12     = res[5];
    out_word.inv_20     = res[6];
    out_word.inv_21     = res[7];
    out_word.inv_22     = res[8];
    out_word.invertible = flag_r;
  end

endmodule
`default_nettype wire

### src/matrix3x3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse.
// Input channel: in_valid / in_stall carry one word, the nine Q16.16 entries.
// Result channel: out_valid / out_stall carry the nine result entries and the
// invertible flag; a word moves at an edge with valid high and stall low.
// Config channel: cfg_valid / cfg_ready write the singular tolerance; ready
// is always high. Write it only while no matrix is in flight.
// Throughput: one matrix per cycle while no stall holds the flow. From acceptance
// to out_valid a matrix passes five front stages, the queue, the lane entry stage,
// the 32-stage restoring divider in each of the nine lanes, rounding and the
// output register.
// When |det| is at or below the tolerance the word holds the rounded
// adjugate and invertible is low.
// Reset clears the queue, all valid flags and the tolerance (to zero).
// A stalled result holds; the back pipe freezes, the front keeps running
// until the two-entry queue fills, and then in_stall rises.
`default_nettype none
module matrix3x3_inverse (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire m3i_pkg::in_word_t          in_word,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output m3i_pkg::out_word_t              out_word,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [m3i_pkg::TOL_W-1:0]  cfg_data
);

  logic [m3i_pkg::TOL_W-1:0] tol_r;
  logic                      q_full, q_empty, push, pop;
  m3i_pkg::item_t            push_item, pop_item;

  assign cfg_ready = 1'b1;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  m3i_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .tol       (tol_r),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  m3i_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  m3i_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

### src/m3i_checker.sv
// Port-level checks for the matrix inverse, bound to the top level.
`default_nettype none
`include "matrix3x3_inverse_defines.svh"
module m3i_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire m3i_pkg::out_word_t out_word
);

  // a waiting result word stays put
  `M3I_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled result changed")

  // reset empties the back pipe
  `M3I_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")

  // reset empties the queue, so input is open
  `M3I_ASSERT_RST(a_rst_in, !rst_n |=> !in_stall, "input stalled after reset")

endmodule

bind matrix3x3_inverse m3i_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW        = m3i_pkg::DW;
  localparam int CW        = m3i_pkg::CW;
  localparam int TOL_W     = m3i_pkg::TOL_W;
  localparam int FRAC_BITS = m3i_pkg::FRAC_BITS;
  typedef m3i_pkg::in_word_t  in_word_t;
  typedef m3i_pkg::out_word_t out_word_t;

  localparam int LATENCY   = 41;
  localparam int WDOG_MAX  = 4000;
  localparam logic [TOL_W-1:0] TOL_MAX = '1;
  localparam logic signed [DW-1:0] ONE = 32'sd65536;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_word_t in_word;
  out_word_t out_word;
  logic [TOL_W-1:0] cfg_data;

  matrix3x3_inverse DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  in_word_t  pending_mats[$];
  out_word_t expected_invs[$];
  logic [TOL_W-1:0] cur_tol;
  logic steady;                 // no idling on either side
  int n_errors, n_in, n_out, n_invertible, n_singular, idle_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // p*q - r*s, exact
  function automatic logic signed [CW:0] cofac(logic signed [DW-1:0] p, logic signed [DW-1:0] q,
                                               logic signed [DW-1:0] r, logic signed [DW-1:0] s);
    logic signed [CW:0] x, y;
    x = p * q;
    y = r * s;
    return x - y;
  endfunction

  // Expected result word for one matrix under a given tolerance
  function automatic out_word_t predict_inverse(in_word_t m, logic [TOL_W-1:0] tol);
    logic signed [CW:0] cf [9];
    logic signed [127:0] det;
    logic [127:0] dmag, tolw, num, quo, rem, lim, sat;
    logic [63:0] mag;
    logic dneg, ok, neg;
    logic [9*DW:0] res;
    cf[0] = cofac(m.a_11, m.a_22, m.a_12, m.a_21);
    cf[1] = cofac(m.a_02, m.a_21, m.a_01, m.a_22);
    cf[2] = cofac(m.a_01, m.a_12, m.a_02, m.a_11);
    cf[3] = cofac(m.a_12, m.a_20, m.a_10, m.a_22);
    cf[4] = cofac(m.a_00, m.a_22, m.a_02, m.a_20);
    cf[5] = cofac(m.a_02, m.a_10, m.a_00, m.a_12);
    cf[6] = cofac(m.a_10, m.a_21, m.a_11, m.a_20);
    cf[7] = cofac(m.a_01, m.a_20, m.a_00, m.a_21);
    cf[8] = cofac(m.a_00, m.a_11, m.a_01, m.a_10);
    det = m.a_00 * cf[0] + m.a_01 * cf[3] + m.a_02 * cf[6];
    dneg = det[127];
    dmag = dneg ? -det : det;
    tolw = {97'b0, tol} << (2 * FRAC_BITS);
    ok = dmag > tolw;
    for (int i = 0; i < 9; i++) begin
      mag = cf[i][CW] ? 64'(-cf[i]) : 64'(cf[i]);
      if (ok) begin
        // round to nearest, ties away from zero
        num = {64'b0, mag} << (2 * FRAC_BITS);
        quo = num / dmag;
        rem = num % dmag;
        if (rem >= dmag - rem) quo = quo + 1;
        neg = cf[i][CW] ^ dneg;
      end else begin
        quo = {64'b0, mag >> FRAC_BITS} + mag[FRAC_BITS-1];
        neg = cf[i][CW];
      end
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      sat = (quo > lim) ? lim : quo;
      res[9*DW - DW*i -: DW] = neg ? -sat[DW-1:0] : sat[DW-1:0];
    end
    res[0] = ok;
    return out_word_t'(res);
  endfunction

  function automatic in_word_t mk(logic signed [DW-1:0] e0, logic signed [DW-1:0] e1,
                                  logic signed [DW-1:0] e2, logic signed [DW-1:0] e3,
                                  logic signed [DW-1:0] e4, logic signed [DW-1:0] e5,
                                  logic signed [DW-1:0] e6, logic signed [DW-1:0] e7,
                                  logic signed [DW-1:0] e8);
    return {e0, e1, e2, e3, e4, e5, e6, e7, e8};
  endfunction

  function automatic logic signed [DW-1:0] rnd_small(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random matrix: full range, modest entries, near singular, or well conditioned
  function automatic in_word_t rnd_matrix();
    in_word_t m;
    int kind;
    logic signed [DW-1:0] e [9];
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) e[i] = rnd_small(4 * 65536);
    case (kind)
      0, 1: begin
        for (int i = 0; i < 9; i++) e[i] = $urandom;
      end
      2: begin
        for (int i = 0; i < 3; i++)
          e[6+i] = e[i] + e[3+i] + rnd_small($urandom_range(0, 1) ? 0 : 64);
      end
      3: begin
        for (int i = 0; i < 9; i++) e[i] = rnd_small(256);
      end
      4: begin
        for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? $signed($urandom) : rnd_small(16);
      end
      5, 6: begin
        for (int i = 0; i < 3; i++) e[4*i] = e[4*i] + ((e[4*i] < 0) ? -20 * ONE : 20 * ONE);
      end
      default: ;
    endcase
    m = mk(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("MISMATCH result %0d %s: got %0d expected %0d", n_out, what, got, want);
  endtask

  // Input driver and prediction on acceptance
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_invs.push_back(predict_inverse(in_word, cur_tol));
        n_in++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_mats.size() > 0) begin
          in_word  <= pending_mats.pop_front();
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and back-pressure
  int stall_left;
  always @(posedge clk) begin
    out_word_t want;
    string names [9];
    names = '{"inv_00", "inv_01", "inv_02", "inv_10", "inv_11", "inv_12",
              "inv_20", "inv_21", "inv_22"};
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_invs.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = expected_invs.pop_front();
          for (int i = 0; i < 9; i++)
            if (out_word[9*DW - DW*i -: DW] !== want[9*DW - DW*i -: DW])
              report_mismatch(names[i], $signed(out_word[9*DW - DW*i -: DW]),
                              $signed(want[9*DW - DW*i -: DW]));
          if (out_word.invertible !== want.invertible)
            report_mismatch("invertible", out_word.invertible, want.invertible);
          if (want.invertible) n_invertible++;
          else n_singular++;
        end
        n_out++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("timeout: no progress, %0d results still expected", expected_invs.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_mats.size() != 0 || in_valid || expected_invs.size() != 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // one write: valid held until the edge that takes it
  task automatic write_tol(logic [TOL_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_tol = v;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) pending_mats.push_back(rnd_matrix());
  endtask

  // Stimulus
  initial begin
    logic [TOL_W-1:0] tols [6];
    logic signed [DW-1:0] mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    rst_n = 1'b0; in_valid = 1'b0; in_word = '0; out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_data = '0; cur_tol = '0; steady = 1'b0;
    n_errors = 0; n_in = 0; n_out = 0; n_invertible = 0; n_singular = 0; idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed matrices at the reset tolerance of zero
    pending_mats.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    pending_mats.push_back(mk(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
    pending_mats.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(mk(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    pending_mats.push_back(mk(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    pending_mats.push_back(mk(mx, 0, 0, 0, mx, 0, 0, 0, mx));
    pending_mats.push_back(mk(mn, 0, 0, 0, mn, 0, 0, 0, mn));
    pending_mats.push_back(mk(mn, mx, 0, mx, mn, mx, 0, mx, mn));
    pending_mats.push_back(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_mats.push_back(mk(-1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_mats.push_back(mk(2 * ONE, ONE, 0, ONE, 2 * ONE, ONE, 0, ONE, 2 * ONE));
    pending_mats.push_back(mk(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                              7 * ONE, 8 * ONE, 9 * ONE));
    pending_mats.push_back(mk(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
    pending_mats.push_back(mk(3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE));
    pending_mats.push_back(mk(32'sh8000, 0, 0, 0, 32'sh8000, 0, 0, 0, 32'sh8000));
    pending_mats.push_back(mk(32'sh18000, 32'sh8000, 0, 0, ONE, 0, 0, 0, ONE));
    pending_mats.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    wait_drained();

    // Tolerance sweep: small, one unit, max, zero, random values
    tols = '{TOL_W'(1), TOL_W'(65536), TOL_MAX, TOL_W'(0), TOL_W'($urandom),
             TOL_W'($urandom_range(0, 4096))};
    foreach (tols[p]) begin
      write_tol(tols[p]);
      steady = (p == 2);
      // determinant sitting on the tolerance: 1.0 * 1.0 * tol
      if (tols[p] != 0) begin
        pending_mats.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, $signed({1'b0, tols[p]})));
        pending_mats.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, $signed({1'b0, tols[p]}) + 1));
      end
      run_random(p == 2 ? 150 : 200);
      wait_drained();
    end

    $display("covered %0d matrices, %0d results: %0d invertible, %0d singular",
             n_in, n_out, n_invertible, n_singular);
    $display("tolerance swept over zero, one unit, full scale and random values");
    if (n_errors == 0 && expected_invs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
